// ----- rtl/tods_pkg.sv -----
// Shared types and constants for the time-of-day clock with stopwatch.
// Holds the item structs, the one-hot mode type and the item kind codes.
// No dependencies.
package tods_pkg;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_BUTTON = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [2:0] CODE_RUN   = 3'd0;
   localparam logic [2:0] CODE_SET_H = 3'd1;
   localparam logic [2:0] CODE_SET_M = 3'd2;
   localparam logic [2:0] CODE_SET_S = 3'd3;
   localparam logic [2:0] CODE_IDLE  = 3'd4;

   localparam logic [10:0] MS_STEP     = 11'd5;
   localparam logic [10:0] MS_PER_SEC  = 11'd1000;
   localparam logic [6:0]  SEC_PER_MIN = 7'd60;
   localparam logic [6:0]  MIN_PER_HR  = 7'd60;
   localparam logic [5:0]  HR_PER_DAY  = 6'd24;

   typedef enum logic [4:0] {
      MODE_RUN     = 5'b00001,
      MODE_SET_H   = 5'b00010,
      MODE_SET_M   = 5'b00100,
      MODE_SET_S   = 5'b01000,
      MODE_STOPPED = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       key_held;
   } req_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [9:0] milliseconds;
      logic [2:0] mode_id;
      logic       fast_tick;
      logic       counting;
   } rsp_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [9:0] milliseconds;
      mode_type   mode;
   } state_type;

endpackage

// ----- rtl/time_of_day_clock_with_stopwatch.sv -----
// Time-of-day clock with set modes and stopwatch: each item is a tick, a mode
// button press or a clear-time command, and each gives one result with the
// time and mode after it. An item enters an input register, is applied to the
// time and mode state, and its result leaves from a result register, so the
// block takes one item per cycle unless a full result register is not taken;
// the state register, updated as each item advances, sets that rate. Writing
// the clock type register also sets the mode: running for the clock, idle for
// the stopwatch. The time is kept. Depends on tods_pkg and tods_step.
module time_of_day_clock_with_stopwatch (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tods_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tods_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import tods_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      type_ff;
   state_type state_ff;
   state_type state_in;
   state_type next_state;
   logic      advance;
   logic      set_mode;
   logic [2:0] mode_code;

   tods_step u_step (
      .use_stopwatch (type_ff),
      .req           (in_data_ff),
      .state         (state_ff),
      .next          (next_state)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (next_state.mode)
         MODE_RUN:     mode_code = CODE_RUN;
         MODE_SET_H:   mode_code = CODE_SET_H;
         MODE_SET_M:   mode_code = CODE_SET_M;
         MODE_SET_S:   mode_code = CODE_SET_S;
         MODE_STOPPED: mode_code = CODE_IDLE;
         default:      mode_code = CODE_RUN;
      endcase
      set_mode = (next_state.mode == MODE_SET_H) || (next_state.mode == MODE_SET_M) ||
                 (next_state.mode == MODE_SET_S);

      rsp_data_in.hours        = next_state.hours;
      rsp_data_in.minutes      = next_state.minutes;
      rsp_data_in.seconds      = next_state.seconds;
      rsp_data_in.milliseconds = next_state.milliseconds;
      rsp_data_in.mode_id      = mode_code;
      rsp_data_in.fast_tick    = !type_ff && set_mode;
      rsp_data_in.counting     = (next_state.mode != MODE_STOPPED);

      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

      state_in = advance ? next_state : state_ff;
      if (csr_valid) begin
         state_in.mode = csr_data ? MODE_STOPPED : MODE_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         type_ff      <= 1'b0;
         state_ff     <= '{hours: 5'd0, minutes: 6'd0, seconds: 6'd0,
                           milliseconds: 10'd0, mode: MODE_RUN};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         if (csr_valid) begin
            type_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_hours_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.hours <= 5'd23) && (rsp_data_ff.minutes <= 6'd59) &&
                       (rsp_data_ff.seconds <= 6'd59) &&
                       (rsp_data_ff.milliseconds <= 10'd995))
      else $error("time value out of range");

   a_idle_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.counting == (rsp_data_ff.mode_id != CODE_IDLE)))
      else $error("counting flag disagrees with mode");

   a_fast_tick : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.fast_tick) |-> (rsp_data_ff.mode_id == CODE_SET_H ||
         rsp_data_ff.mode_id == CODE_SET_M || rsp_data_ff.mode_id == CODE_SET_S))
      else $error("fast tick outside a set mode");

   a_item_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("stalled item lost");
`endif

endmodule

// ----- rtl/tods_step.sv -----
// Next-state logic of the clock: applies one item to the time and mode.
// Handles ticks with carry ripple, button mode cycling and clear time;
// starting the stopwatch from idle zeroes it. Depends on tods_pkg.
module tods_step (
   input  logic               use_stopwatch,
   input  tods_pkg::req_type   req,
   input  tods_pkg::state_type state,
   output tods_pkg::state_type next
);
   import tods_pkg::*;

   logic        add_ms;
   logic        add_s;
   logic        add_m;
   logic        add_h;
   logic [10:0] ms_sum;
   logic        ms_carry;
   logic [6:0]  s_sum;
   logic        s_carry;
   logic [6:0]  m_sum;
   logic        m_carry;
   logic [5:0]  h_sum;
   state_type   ticked;
   mode_type    pressed;

   always_comb begin
      add_ms = use_stopwatch && (state.mode == MODE_RUN);
      add_s  = !use_stopwatch && ((state.mode == MODE_RUN) ||
                                  ((state.mode == MODE_SET_S) && req.key_held));
      add_m  = !use_stopwatch && (state.mode == MODE_SET_M) && req.key_held;
      add_h  = !use_stopwatch && (state.mode == MODE_SET_H) && req.key_held;

      ms_sum   = {1'b0, state.milliseconds} + (add_ms ? MS_STEP : 11'd0);
      ms_carry = (ms_sum >= MS_PER_SEC);
      s_sum    = {1'b0, state.seconds} + {6'd0, add_s | ms_carry};
      s_carry  = (s_sum >= SEC_PER_MIN);
      m_sum    = {1'b0, state.minutes} + {6'd0, add_m | s_carry};
      m_carry  = (m_sum >= MIN_PER_HR);
      h_sum    = {1'b0, state.hours} + {5'd0, add_h | m_carry};

      ticked              = state;
      ticked.milliseconds = ms_carry ? 10'd0 : ms_sum[9:0];
      ticked.seconds      = s_carry ? 6'd0 : s_sum[5:0];
      ticked.minutes      = m_carry ? 6'd0 : m_sum[5:0];
      ticked.hours        = (h_sum >= HR_PER_DAY) ? 5'd0 : h_sum[4:0];
   end

   always_comb begin
      pressed = state.mode;
      if (!use_stopwatch) begin
         case (state.mode)
            MODE_RUN:   pressed = MODE_SET_H;
            MODE_SET_H: pressed = MODE_SET_M;
            MODE_SET_M: pressed = MODE_SET_S;
            MODE_SET_S: pressed = MODE_RUN;
            default:    pressed = state.mode;
         endcase
      end else begin
         case (state.mode)
            MODE_STOPPED: pressed = MODE_RUN;
            MODE_RUN:     pressed = MODE_STOPPED;
            default:      pressed = state.mode;
         endcase
      end
   end

   always_comb begin
      next = state;
      case (req.mode)
         KIND_TICK: begin
            next = ticked;
         end
         KIND_BUTTON: begin
            next.mode = pressed;
            if (use_stopwatch && (state.mode == MODE_STOPPED)) begin
               next.hours        = 5'd0;
               next.minutes      = 6'd0;
               next.seconds      = 6'd0;
               next.milliseconds = 10'd0;
            end
         end
         KIND_CLEAR: begin
            next.hours        = 5'd0;
            next.minutes      = 6'd0;
            next.seconds      = 6'd0;
            next.milliseconds = 10'd0;
         end
         default: begin
            next = state;
         end
      endcase
   end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the time-of-day clock with stopwatch.
// A directed table, then random tick, button and clear items, each checked
// against a table value or an in-testbench model. Depends on tods_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import tods_pkg::*;

   localparam logic [1:0] KIND_UNUSED    = 2'd3;
   localparam logic       TYPE_CLOCK     = 1'b0;
   localparam logic       TYPE_TIMER     = 1'b1;
   localparam int         RANDOM_PHASES  = 12;
   localparam int         PHASE_ITEMS    = 135;

   localparam rsp_type AT_ONE_SEC = '{5'd0, 6'd0, 6'd1, 10'd0, CODE_RUN, 1'b0, 1'b1};
   localparam rsp_type ZERO_RUN   = '{5'd0, 6'd0, 6'd0, 10'd0, CODE_RUN, 1'b0, 1'b1};
   localparam rsp_type ZERO_SET_H = '{5'd0, 6'd0, 6'd0, 10'd0, CODE_SET_H, 1'b1, 1'b1};

   typedef struct {
      bit      is_cfg;
      bit      cfg_value;
      req_type item;
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   logic [4:0] tod_hours = '0;
   logic [5:0] tod_minutes = '0;
   logic [5:0] tod_seconds = '0;
   logic [9:0] tod_millis = '0;
   logic [2:0] tod_mode = CODE_RUN;
   logic       tod_type = TYPE_CLOCK;

   rsp_type      expected_times[$];
   rsp_type      head_want;
   plan_row_type plan[$];

   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int cfg_writes = 0;

   logic [15:0] ready_pattern = 16'hFFFF;
   logic [7:0]  ready_age = '0;

   time_of_day_clock_with_stopwatch u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type advance_clock(req_type item);
      int      h;
      int      m;
      int      s;
      int      ms;
      rsp_type r;
      h  = tod_hours;
      m  = tod_minutes;
      s  = tod_seconds;
      ms = tod_millis;
      case (item.mode)
         KIND_TICK: begin
            if (tod_type == TYPE_CLOCK) begin
               if (tod_mode == CODE_RUN) s++;
               else if (tod_mode == CODE_SET_S && item.key_held) s++;
               else if (tod_mode == CODE_SET_M && item.key_held) m++;
               else if (tod_mode == CODE_SET_H && item.key_held) h++;
            end else if (tod_mode == CODE_RUN) begin
               ms += 5;
            end
            if (ms >= 1000) begin
               ms = 0;
               s++;
            end
            if (s >= 60) begin
               s = 0;
               m++;
            end
            if (m >= 60) begin
               m = 0;
               h++;
            end
            if (h >= 24) h = 0;
         end
         KIND_BUTTON: begin
            if (tod_type == TYPE_CLOCK) begin
               if (tod_mode == CODE_RUN) tod_mode = CODE_SET_H;
               else if (tod_mode == CODE_SET_H) tod_mode = CODE_SET_M;
               else if (tod_mode == CODE_SET_M) tod_mode = CODE_SET_S;
               else if (tod_mode == CODE_SET_S) tod_mode = CODE_RUN;
            end else if (tod_mode == CODE_IDLE) begin
               tod_mode = CODE_RUN;
               h = 0;
               m = 0;
               s = 0;
               ms = 0;
            end else if (tod_mode == CODE_RUN) begin
               tod_mode = CODE_IDLE;
            end
         end
         KIND_CLEAR: begin
            h = 0;
            m = 0;
            s = 0;
            ms = 0;
         end
         default: ;
      endcase
      tod_hours   = h[4:0];
      tod_minutes = m[5:0];
      tod_seconds = s[5:0];
      tod_millis  = ms[9:0];
      r.hours        = tod_hours;
      r.minutes      = tod_minutes;
      r.seconds      = tod_seconds;
      r.milliseconds = tod_millis;
      r.mode_id      = tod_mode;
      r.fast_tick    = (tod_type == TYPE_CLOCK) && (tod_mode == CODE_SET_H ||
                       tod_mode == CODE_SET_M || tod_mode == CODE_SET_S);
      r.counting     = (tod_mode != CODE_IDLE);
      return r;
   endfunction

   function automatic plan_row_type step_row(logic [1:0] kind, logic key, bit typed,
                                             rsp_type want);
      plan_row_type row;
      row.is_cfg        = 1'b0;
      row.cfg_value     = 1'b0;
      row.item.mode     = kind;
      row.item.key_held = key;
      row.typed         = typed;
      row.want          = want;
      return row;
   endfunction

   function automatic plan_row_type cfg_row(logic value);
      plan_row_type row;
      row.is_cfg    = 1'b1;
      row.cfg_value = value;
      row.item      = '0;
      row.typed     = 1'b0;
      row.want      = '0;
      return row;
   endfunction

   task automatic push_item(req_type item, bit typed, rsp_type want);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted = advance_clock(item);
      expected_times.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic write_type(logic value);
      req_valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tod_type = value;
      tod_mode = (value == TYPE_CLOCK) ? CODE_RUN : CODE_IDLE;
      cfg_writes++;
   endtask

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   // The receiver follows a rotating ready pattern that is redrawn now and then.
   always @(posedge clock) begin
      if (ready_age == 0)
         ready_pattern = ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      ready_age = ready_age + 8'd1;
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      rsp_ready <= ready_pattern[0];
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_times.size() == 0) begin
            $display("%0t: result with no item waiting, actual %p", $time, rsp_data);
            errors++;
         end else begin
            head_want = expected_times.pop_front();
            check_field("hours", head_want.hours, rsp_data.hours);
            check_field("minutes", head_want.minutes, rsp_data.minutes);
            check_field("seconds", head_want.seconds, rsp_data.seconds);
            check_field("milliseconds", head_want.milliseconds, rsp_data.milliseconds);
            check_field("mode_id", head_want.mode_id, rsp_data.mode_id);
            check_field("fast_tick", head_want.fast_tick, rsp_data.fast_tick);
            check_field("counting", head_want.counting, rsp_data.counting);
            results_checked++;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_type item;
      int      run_left;
      int      pick;
      int      counted;
      int      burst;
      plan.push_back(step_row(KIND_TICK, 1'b0, 1'b1, AT_ONE_SEC));
      plan.push_back(step_row(KIND_UNUSED, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_CLEAR, 1'b0, 1'b1, ZERO_RUN));
      plan.push_back(step_row(KIND_BUTTON, 1'b0, 1'b1, ZERO_SET_H));
      plan.push_back(step_row(KIND_TICK, 1'b0, 1'b0, '0));
      plan.push_back(step_row(KIND_TICK, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_BUTTON, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_TICK, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_BUTTON, 1'b0, 1'b0, '0));
      plan.push_back(step_row(KIND_TICK, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_TICK, 1'b0, 1'b0, '0));
      plan.push_back(step_row(KIND_BUTTON, 1'b0, 1'b0, '0));
      plan.push_back(step_row(KIND_TICK, 1'b1, 1'b0, '0));
      plan.push_back(cfg_row(TYPE_TIMER));
      plan.push_back(step_row(KIND_TICK, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_UNUSED, 1'b0, 1'b0, '0));
      plan.push_back(step_row(KIND_BUTTON, 1'b0, 1'b1, ZERO_RUN));
      plan.push_back(step_row(KIND_TICK, 1'b0, 1'b0, '0));
      plan.push_back(step_row(KIND_BUTTON, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_TICK, 1'b0, 1'b0, '0));
      plan.push_back(step_row(KIND_BUTTON, 1'b0, 1'b1, ZERO_RUN));
      plan.push_back(step_row(KIND_TICK, 1'b1, 1'b0, '0));
      plan.push_back(step_row(KIND_CLEAR, 1'b1, 1'b1, ZERO_RUN));
      plan.push_back(cfg_row(TYPE_CLOCK));
      plan.push_back(step_row(KIND_TICK, 1'b1, 1'b0, '0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_type(plan[i].cfg_value);
         else push_item(plan[i].item, plan[i].typed, plan[i].want);
      end

      // Random part: mostly runs of ticks with random key state between button
      // presses, so the set modes wrap hours and minutes and the stopwatch
      // carries into seconds; clears and unused kinds are mixed in as noise.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_type(phase[0] ? TYPE_TIMER : TYPE_CLOCK);
         counted  = 0;
         run_left = 0;
         while (counted < PHASE_ITEMS) begin
            burst = ($urandom_range(4) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
            if (burst > PHASE_ITEMS - counted) burst = PHASE_ITEMS - counted;
            repeat (burst) begin
               if (run_left != 0) begin
                  item.mode     = KIND_TICK;
                  item.key_held = ($urandom_range(9) != 0);
                  run_left--;
               end else begin
                  pick          = $urandom_range(99);
                  item.key_held = 1'($urandom_range(1));
                  if (pick < 60) begin
                     item.mode = KIND_TICK;
                     run_left  = (tod_type == TYPE_CLOCK) ? $urandom_range(1, 60)
                                                          : $urandom_range(1, 250);
                  end else if (pick < 88) begin
                     item.mode = KIND_BUTTON;
                  end else if (pick < 94) begin
                     item.mode = KIND_CLEAR;
                  end else begin
                     item.mode = KIND_UNUSED;
                  end
               end
               push_item(item, 1'b0, '0);
               if (item.mode != KIND_UNUSED) counted++;
            end
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d items in clock and stopwatch types across %0d type writes.",
               items_sent, cfg_writes);
      $display("%0d results were compared field by field, %0d mismatches.",
               results_checked, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
